[rtl/core/snb_pkg.sv]
`default_nettype none

package snb_pkg;

	// Sample width and derived datapath widths
	localparam int SAMPLE_BITS = 16;
	localparam int NUM_W       = SAMPLE_BITS + 8;
	localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PIX_W       = 8;

	// Request codes carried on the input tuser
	localparam logic [1:0] REQ_GATHER  = 2'd0;
	localparam logic [1:0] REQ_CONVERT = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	// Queue between the front and back parts (depth must be a power of two)
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One classified item on its way to the back part
	typedef struct packed {
		logic                   conv;
		logic                   zero;
		logic                   smode;
		logic [SAMPLE_BITS-1:0] peak;
		logic [NUM_W-1:0]       num;
	} snb_entry_t;

endpackage

`default_nettype wire

[rtl/core/snb_front.sv]
`default_nettype none

module snb_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [snb_pkg::DATA_W-1:0] s_tdata,
	input  wire logic [1:0]               s_tuser,
	input  wire logic                     q_full,
	output logic                          q_push,
	output snb_pkg::snb_entry_t           q_entry
);
	import snb_pkg::*;

	logic [SAMPLE_BITS-1:0] peak_q;
	logic                   neg_q;
	logic [SAMPLE_BITS-1:0] peak_n;
	logic                   neg_n;

	logic [SAMPLE_BITS-1:0] sample;
	logic                   is_neg;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS+1:0] sum;
	logic                   sum_pos;
	logic                   p_pos;
	logic [NUM_W-1:0]       num_sgn;
	logic [NUM_W-1:0]       num_uns;

	// Take the sample apart: sign, magnitude, offset by the peak
	always_comb begin
		sample  = s_tdata[SAMPLE_BITS-1:0];
		is_neg  = sample[SAMPLE_BITS-1];
		mag     = is_neg ? (~sample + 1'b1) : sample;
		sum     = {{2{sample[SAMPLE_BITS-1]}}, sample} + {2'b00, peak_q};
		sum_pos = !sum[SAMPLE_BITS+1] && (sum != '0);
		p_pos   = !is_neg && (sample != '0);
		num_sgn = NUM_W'(sum[SAMPLE_BITS:0]) * NUM_W'(127);
		num_uns = NUM_W'(sample[SAMPLE_BITS-2:0]) * NUM_W'(255);
	end

	// Fold gather and clear requests into the frame statistics
	always_comb begin
		peak_n = peak_q;
		neg_n  = neg_q;
		unique case (s_tuser)
			REQ_GATHER: begin
				neg_n = neg_q | is_neg;
				if (mag > peak_q) begin
					peak_n = mag;
				end
			end
			REQ_CLEAR: begin
				peak_n = '0;
				neg_n  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Build the queue entry; convert uses the statistics before this item
	always_comb begin
		q_entry.conv  = (s_tuser == REQ_CONVERT);
		q_entry.zero  = (peak_q == '0) || (neg_q ? !sum_pos : !p_pos);
		q_entry.smode = neg_n;
		q_entry.peak  = peak_q;
		q_entry.num   = neg_q ? num_sgn : num_uns;
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Update statistics on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			neg_q  <= 1'b0;
		end else if (q_push) begin
			peak_q <= peak_n;
			neg_q  <= neg_n;
		end
	end

endmodule

`default_nettype wire

[rtl/core/snb_queue.sv]
`default_nettype none

module snb_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire snb_pkg::snb_entry_t push_entry,
	input  wire logic                pop,
	output snb_pkg::snb_entry_t      pop_entry,
	output logic                     full,
	output logic                     empty
);
	import snb_pkg::*;

	snb_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/snb_back.sv]
`default_nettype none

module snb_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_empty,
	input  wire snb_pkg::snb_entry_t        q_entry,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [snb_pkg::PIX_W-1:0]       m_tdata,
	output logic [1:0]                      m_tuser
);
	import snb_pkg::*;

	localparam logic       ST_IDLE = 1'b0;
	localparam logic       ST_DIV  = 1'b1;
	localparam logic [3:0] CNT_SAT = 4'd8;

	logic             state_q;
	logic [3:0]       cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsr_q;
	logic [PIX_W-1:0] quo_q;
	logic             smode_q;
	logic             m_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic             conv_q;
	logic             omode_q;

	logic             out_free;
	logic             ge;
	logic [NUM_W-1:0] diff;

	assign out_free = !m_valid_q || m_tready;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty && out_free;
	assign ge       = (rem_q >= dsr_q);
	assign diff     = rem_q - dsr_q;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = pixel_q;
	assign m_tuser  = {omode_q, conv_q};

	// Restoring division, one quotient bit a cycle; first step checks saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			dsr_q     <= '0;
			quo_q     <= '0;
			smode_q   <= 1'b0;
			m_valid_q <= 1'b0;
			pixel_q   <= '0;
			conv_q    <= 1'b0;
			omode_q   <= 1'b0;
		end else begin
			// Drop a taken result; a pop sets the output register itself
			if (m_valid_q && m_tready && !q_pop) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_entry.conv && !q_entry.zero) begin
							rem_q     <= q_entry.num;
							dsr_q     <= NUM_W'(q_entry.peak) << PIX_W;
							quo_q     <= '0;
							cnt_q     <= CNT_SAT;
							smode_q   <= q_entry.smode;
							m_valid_q <= 1'b0;
							state_q   <= ST_DIV;
						end else begin
							pixel_q   <= '0;
							conv_q    <= q_entry.conv;
							omode_q   <= q_entry.smode;
							m_valid_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_SAT) begin
						if (ge) begin
							pixel_q   <= '1;
							conv_q    <= 1'b1;
							omode_q   <= smode_q;
							m_valid_q <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							dsr_q <= dsr_q >> 1;
							cnt_q <= cnt_q - 1'b1;
						end
					end else begin
						rem_q <= ge ? diff : rem_q;
						quo_q <= {quo_q[PIX_W-2:0], ge};
						dsr_q <= dsr_q >> 1;
						if (cnt_q == '0) begin
							pixel_q   <= {quo_q[PIX_W-2:0], ge};
							conv_q    <= 1'b1;
							omode_q   <= smode_q;
							m_valid_q <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/signed_peak_normalize_to_byte_unit.sv]
// Peak normalization of signed samples to 8-bit grey levels.
// Input stream: s_tdata carries the sample, s_tuser the request
// (gather statistics, convert sample, clear for a new frame).
// Output stream: one transaction per input; m_tdata is the grey level,
// m_tuser flags a conversion result and the frame's signed mode.
// The front part updates the frame peak and negative flag as each
// transaction is accepted and classifies the item into a two-entry queue.
// The back part runs a restoring divider by the gathered peak, one
// quotient bit a cycle: a convert item occupies it through its pop, a
// saturation check and 8 quotient bits, or to the check if it saturates.
// Gather, clear, zero-peak and below-range converts leave it at the pop,
// where the output register takes their result; a saturated convert sets
// that register at the check, a full division with the last quotient bit.
// Reset clears the statistics, the queue and the output register.
// When the receiver stalls the result holds in the output register; the
// queue keeps filling and s_tready drops once both entries are taken.
`default_nettype none

module signed_peak_normalize_to_byte_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [snb_pkg::DATA_W-1:0]   s_tdata,  // [15:0] sample
	input  wire logic [1:0]                   s_tuser,  // [1:0] req_type
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [snb_pkg::PIX_W-1:0]         m_tdata,  // [7:0] pixel
	output logic [1:0]                        m_tuser   // [0] converted, [1] signed_mode
);
	import snb_pkg::*;

	snb_entry_t push_entry;
	snb_entry_t pop_entry;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;

	// Accept and classify
	snb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	// Decouple front and back
	snb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	// Divide and deliver
	snb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (pop_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
